### rtl/pfap_pkg.sv
// Shared constants, register codes and types for the perspective floor parameter block.
package pfap_pkg;

  localparam int unsigned ScreenLines = 160;
  localparam int unsigned QuotW = 32;

  // Configuration register indexes.
  localparam logic [2:0] REG_FOCAL   = 3'd0;
  localparam logic [2:0] REG_HORIZON = 3'd1;
  localparam logic [2:0] REG_EYE     = 3'd2;
  localparam logic [2:0] REG_SCALE   = 3'd3;
  localparam logic [2:0] REG_CAMX    = 3'd4;
  localparam logic [2:0] REG_CAMY    = 3'd5;
  localparam logic [2:0] REG_SINE    = 3'd6;
  localparam logic [2:0] REG_COSINE  = 3'd7;

  // Per-item side information carried next to the divider.
  typedef struct packed {
    logic       offscreen;
    logic [7:0] line;
  } div_tag_t;

endpackage

### rtl/pfap_div.sv
// Pipelined signed divider, one quotient bit per stage after stage 0, one word per cycle while en is high.
module pfap_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [31:0]             num,
  input  logic [8:0]              den,
  input  pfap_pkg::div_tag_t      in_tag,
  output logic                    out_valid,
  output logic [31:0]             quot,
  output pfap_pkg::div_tag_t      out_tag
);

  localparam int unsigned N = pfap_pkg::QuotW;

  logic [N:0]                    vld_r;
  logic [N:0][31:0]              rem_r;
  logic [N:0][31:0]              q_r;
  logic [N:0][8:0]               d_r;
  logic [N:0]                    neg_r;
  logic [N:0]                    zero_r;
  pfap_pkg::div_tag_t [N:0]      tag_r;

  // Stage 0 takes magnitudes; stage k+1 develops quotient bit N-1-k.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num[31] ? (32'd0 - num) : num;
      d_r[0]    <= den[8] ? (9'd0 - den) : den;
      neg_r[0]  <= num[31] ^ den[8];
      zero_r[0] <= (den == 9'd0);
      q_r[0]    <= '0;
      tag_r[0]  <= in_tag;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int unsigned B = N - 1 - k;
    logic [40:0] shd;
    logic        take;
    always_comb begin
      shd  = {9'd0, rem_r[k]} >> B;
      take = (shd >= {32'd0, d_r[k]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= take ? (rem_r[k] - 32'({d_r[k]} << B)) : rem_r[k];
        q_r[k+1]    <= q_r[k] | (32'(take) << B);
        d_r[k+1]    <= d_r[k];
        neg_r[k+1]  <= neg_r[k];
        zero_r[k+1] <= zero_r[k];
        tag_r[k+1]  <= tag_r[k];
      end
    end
  end

  assign out_valid = vld_r[N];
  assign quot      = zero_r[N] ? 32'd0 : (neg_r[N] ? (32'd0 - q_r[N]) : q_r[N]);
  assign out_tag   = tag_r[N];

endmodule

### rtl/pfap_math.sv
// Multiply stages that turn a depth quotient into affine coefficients and start point.
module pfap_math (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [31:0]         depth,
  input  pfap_pkg::div_tag_t  in_tag,
  input  logic [15:0]         focal_line,
  input  logic [15:0]         eye_height,
  input  logic [15:0]         depth_scale,
  input  logic [31:0]         camera_x,
  input  logic [31:0]         camera_y,
  input  logic [15:0]         sine_value,
  input  logic [15:0]         cosine_value,
  output logic                out_valid,
  output logic [111:0]        out_word
);

  logic [3:0] vld_r;
  logic [3:0] off_r;
  logic [7:0] line1_r;
  logic [31:0] d1_r;
  logic [31:0] s1, c1;
  logic [31:0] t1, e_nxt, v_nxt;
  logic [31:0] e2_r, v2_r, d2_r;
  logic [31:0] di, ei, vi;
  logic [31:0] pa_r, pb_r, vs_r, ec_r, es_r, vc_r;
  logic [15:0] ca_r, cb_r, cc_r;
  logic [31:0] sx, sy;
  logic [23:0] sx_r, sy_r;

  assign s1 = {{16{sine_value[15]}}, sine_value} << 2;
  assign c1 = {{16{cosine_value[15]}}, cosine_value} << 2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  // Stage 1: scale depth.
  always_ff @(posedge clk) begin
    if (en) begin
      d1_r    <= depth * {{16{depth_scale[15]}}, depth_scale};
      line1_r <= in_tag.line;
      off_r[0] <= in_tag.offscreen;
    end
  end

  // Stage 2: eye and vertical terms.
  assign t1    = $signed(d1_r) >>> 8;
  assign e_nxt = (32'd0 - {{16{eye_height[15]}}, eye_height}) * t1;
  assign v_nxt = (({24'd0, line1_r} - {{16{focal_line[15]}}, focal_line}) * t1) << 1;
  always_ff @(posedge clk) begin
    if (en) begin
      e2_r <= e_nxt;
      v2_r <= v_nxt;
      d2_r <= d1_r;
      off_r[1] <= off_r[0];
    end
  end

  // Stage 3: rotate by the bearing.
  assign di = $signed(d2_r) >>> 16;
  assign ei = $signed(e2_r) >>> 16;
  assign vi = $signed(v2_r) >>> 16;
  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= di * c1;
      pb_r <= di * s1;
      vs_r <= vi * s1;
      ec_r <= ei * c1;
      es_r <= ei * s1;
      vc_r <= vi * c1;
      off_r[2] <= off_r[1];
    end
  end

  // Stage 4: sums, shifts and the past-screen clamp.
  assign sx = vs_r + ec_r + camera_x;
  assign sy = vc_r - es_r + camera_y;
  always_ff @(posedge clk) begin
    if (en) begin
      ca_r <= off_r[2] ? 16'd0 : pa_r[31:16];
      cb_r <= off_r[2] ? 16'd0 : pb_r[31:16];
      cc_r <= off_r[2] ? 16'd0 : 16'(($signed(32'd0 - pb_r)) >>> 16);
      sx_r <= off_r[2] ? 24'd0 : sx[31:8];
      sy_r <= off_r[2] ? 24'd0 : sy[31:8];
      off_r[3] <= off_r[2];
    end
  end

  assign out_valid = vld_r[3];
  assign out_word  = {sy_r, sx_r, ca_r, cc_r, cb_r, ca_r};

endmodule

### rtl/perspective_floor_affine_params.sv
// Top level: configuration registers, divider, multiply stages and output register.
// Throughput: one word per cycle unless stalled; the 33-stage divider and 4 multiply
// stages advance together and hold while the output register is full and stalled.
// Reset: synchronous active-low rst_n clears all valid bits and the configuration
// registers: depth_scale to 256, every other to 0; data registers are not reset.
module perspective_floor_affine_params (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // line_index
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // coef_a, coef_b, coef_c, coef_d, start_x, start_y
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [15:0] focal_r, eye_r, scale_r, sin_r, cos_r;
  logic [7:0]  horizon_r;
  logic [31:0] camx_r, camy_r;

  // Configuration writes.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r <= '0; horizon_r <= '0; eye_r <= '0; scale_r <= 16'd256;
      camx_r <= '0; camy_r <= '0; sin_r <= '0; cos_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pfap_pkg::REG_FOCAL:   focal_r   <= cfg_data[15:0];
        pfap_pkg::REG_HORIZON: horizon_r <= cfg_data[7:0];
        pfap_pkg::REG_EYE:     eye_r     <= cfg_data[15:0];
        pfap_pkg::REG_SCALE:   scale_r   <= cfg_data[15:0];
        pfap_pkg::REG_CAMX:    camx_r    <= cfg_data;
        pfap_pkg::REG_CAMY:    camy_r    <= cfg_data;
        pfap_pkg::REG_SINE:    sin_r     <= cfg_data[15:0];
        pfap_pkg::REG_COSINE:  cos_r     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Pipeline advances unless the output holding stage is full and stalled.
  logic out_full_r;
  logic [111:0] out_word_r;
  logic en;
  assign en = !out_full_r || out_tready;
  assign in_tready = en;

  logic [31:0] num;
  logic [8:0]  den;
  pfap_pkg::div_tag_t tag;
  assign num = ({{16{focal_r[15]}}, focal_r} - {24'd0, horizon_r}) << 16;
  assign den = {1'b0, in_tdata} - {1'b0, horizon_r};
  assign tag.line = in_tdata;
  assign tag.offscreen = ({24'd0, in_tdata} >= 32'(pfap_pkg::ScreenLines));

  logic dv;
  logic [31:0] q;
  pfap_pkg::div_tag_t qtag;

  pfap_div u_div (
    .clk, .rst_n, .en,
    .in_valid(in_tvalid), .num, .den, .in_tag(tag),
    .out_valid(dv), .quot(q), .out_tag(qtag)
  );

  logic mv;
  logic [111:0] mword;

  pfap_math u_math (
    .clk, .rst_n, .en,
    .in_valid(dv), .depth(q), .in_tag(qtag),
    .focal_line(focal_r), .eye_height(eye_r), .depth_scale(scale_r),
    .camera_x(camx_r), .camera_y(camy_r),
    .sine_value(sin_r), .cosine_value(cos_r),
    .out_valid(mv), .out_word(mword)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_full_r <= 1'b0;
    end else if (en) begin
      out_full_r <= mv;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r <= mword;
    end
  end

  assign out_tvalid = out_full_r;
  assign out_tdata  = out_word_r;

endmodule

### rtl/pfap_checker.sv
// Port-level checks for the perspective floor parameter block, bound to the top level.
module pfap_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata,
  input logic         cfg_ready
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  a_coef_d: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[63:48] == out_tdata[15:0])
    else $error("coef_d differs from coef_a");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind perspective_floor_affine_params pfap_checker u_pfap_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .cfg_ready
);
